// File: src/assert_macros.svh
// assertion macros used by the checker module
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define GSA_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("gsa assertion failed");

// next-cycle implication, disabled during reset
`define GSA_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("gsa assertion failed");

`endif

// File: src/gsa_pkg.sv
// types, codes and sizes of the generational slot allocator
// no dependencies
package gsa_pkg;

  localparam int SlotDepth       = 256;
  localparam int IdxW            = 8;
  localparam int GenW            = 8;
  localparam int ShapeW          = 2;
  localparam int LayerW          = 32;
  localparam int KindW           = 3;
  localparam int CntW            = 8;
  localparam int HwW             = 9;
  localparam int DefMaxSlotIndex = 255;
  localparam int GroupSize       = 16;
  localparam int NumGroups       = SlotDepth / GroupSize;
  localparam int BitIdxW         = $clog2(GroupSize);
  localparam int GrpIdxW         = $clog2(NumGroups);

  localparam logic [KindW-1:0] KIND_ACQUIRE   = 3'd0;
  localparam logic [KindW-1:0] KIND_RELEASE   = 3'd1;
  localparam logic [KindW-1:0] KIND_CHECK     = 3'd2;
  localparam logic [KindW-1:0] KIND_SET_LAYER = 3'd3;
  localparam logic [KindW-1:0] KIND_CLEAR     = 3'd4;

  localparam logic [ShapeW-1:0] SHAPE_NONE   = 2'd0;
  localparam logic [ShapeW-1:0] SHAPE_BOX    = 2'd1;
  localparam logic [ShapeW-1:0] SHAPE_SPHERE = 2'd2;

  typedef enum logic [2:0] {
    OP_ACQUIRE,
    OP_RELEASE,
    OP_CHECK,
    OP_SET_LAYER,
    OP_CLEAR,
    OP_REJECT,
    OP_NOP
  } op_e;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [IdxW-1:0]   handle_index;
    logic [GenW-1:0]   handle_generation;
    logic [ShapeW-1:0] shape_kind;
    logic [LayerW-1:0] layer_bits;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [IdxW-1:0]   slot_index;
    logic [GenW-1:0]   slot_generation;
    logic [LayerW-1:0] slot_layer;
    logic [ShapeW-1:0] slot_shape;
    logic [CntW-1:0]   live_count;
  } rsp_t;

  typedef struct packed {
    op_e  op;
    logic handle_ok;
    req_t req;
  } item_t;

  typedef struct packed {
    logic [GenW-1:0]   gen;
    logic [ShapeW-1:0] shape;
    logic [LayerW-1:0] layer;
  } entry_t;

endpackage

// File: src/gsa_front.sv
// front end: classifies incoming transactions and queues them for the back end
// depends on gsa_pkg
module gsa_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  gsa_pkg::req_t req_i,
  output logic          item_valid_o,
  input  logic          item_pop_i,
  output gsa_pkg::item_t item_o
);

  gsa_pkg::item_t fifo_q [2];
  gsa_pkg::item_t item_in;
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           push_ok, pop_ok;

  always_comb begin
    item_in           = '0;
    item_in.req       = req_i;
    item_in.handle_ok = (req_i.handle_index != '0) && (req_i.handle_generation != '0);
    unique case (req_i.kind)
      gsa_pkg::KIND_ACQUIRE: begin
        if (req_i.shape_kind == gsa_pkg::SHAPE_BOX || req_i.shape_kind == gsa_pkg::SHAPE_SPHERE) begin
          item_in.op = gsa_pkg::OP_ACQUIRE;
        end else begin
          item_in.op = gsa_pkg::OP_REJECT;
        end
      end
      gsa_pkg::KIND_RELEASE:   item_in.op = gsa_pkg::OP_RELEASE;
      gsa_pkg::KIND_CHECK:     item_in.op = gsa_pkg::OP_CHECK;
      gsa_pkg::KIND_SET_LAYER: item_in.op = gsa_pkg::OP_SET_LAYER;
      gsa_pkg::KIND_CLEAR:     item_in.op = gsa_pkg::OP_CLEAR;
      default:                 item_in.op = gsa_pkg::OP_NOP;
    endcase
  end

  assign full         = (cnt_q == 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = fifo_q[rd_ptr_q];
  assign push_ok      = push && !full;
  assign pop_ok       = item_pop_i && item_valid_o;

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      fifo_q[wr_ptr_q] <= item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_ok) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_ok) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_ok && !pop_ok) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_ok && !push_ok) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// File: src/gsa_back.sv
// back end: slot table, free-slot search and result register
// depends on gsa_pkg
module gsa_back #(
  parameter int MaxSlotIndex = gsa_pkg::DefMaxSlotIndex
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  output logic           item_pop_o,
  input  gsa_pkg::item_t item_i,
  output logic           empty,
  input  logic           pop,
  output gsa_pkg::rsp_t  rsp_o
);

  localparam int TopIndex = (MaxSlotIndex > gsa_pkg::SlotDepth - 1) ?
                            gsa_pkg::SlotDepth - 1 : MaxSlotIndex;
  localparam logic [gsa_pkg::IdxW-1:0] TopIdx = gsa_pkg::IdxW'(TopIndex);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FIND,
    S_ACQ
  } state_e;

  function automatic logic [gsa_pkg::BitIdxW:0] first_set(
    logic [gsa_pkg::GroupSize-1:0] v
  );
    logic [gsa_pkg::BitIdxW:0] r;
    r = '0;
    for (int i = gsa_pkg::GroupSize - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = {1'b1, gsa_pkg::BitIdxW'(i)};
      end
    end
    return r;
  endfunction

  state_e                         state_q, state_d;
  logic [gsa_pkg::SlotDepth-1:0]  active_q, active_d;
  logic [gsa_pkg::HwW-1:0]        hw_q, hw_d;
  logic [gsa_pkg::CntW-1:0]       cnt_q, cnt_d;
  logic                           rsp_valid_q, rsp_valid_d;
  gsa_pkg::rsp_t                  rsp_q, rsp_d;
  logic                           done;

  gsa_pkg::item_t                 cur_q;
  logic [gsa_pkg::GrpIdxW-1:0]    grp_q;
  logic                           grp_found_q;
  logic [gsa_pkg::IdxW-1:0]       f_q;
  logic                           grant_q;

  gsa_pkg::entry_t                mem_q [gsa_pkg::SlotDepth];
  gsa_pkg::entry_t                rd_q;
  logic [gsa_pkg::IdxW-1:0]       rd_addr;
  logic                           mem_we;
  logic [gsa_pkg::IdxW-1:0]       mem_waddr;
  gsa_pkg::entry_t                mem_wdata;

  logic [gsa_pkg::SlotDepth-1:0]  act_eff;
  logic [gsa_pkg::NumGroups-1:0][gsa_pkg::GroupSize-1:0] act_grp;
  logic [gsa_pkg::NumGroups-1:0]  grp_free;
  logic [gsa_pkg::GrpIdxW:0]      grp_pick;
  logic [gsa_pkg::BitIdxW:0]      bit_pick;
  logic [gsa_pkg::IdxW-1:0]       f_idx;
  logic                           f_grant;
  logic                           start;
  logic                           live;
  logic [gsa_pkg::GenW-1:0]       gen_old, gen_inc, gen_new;

  // slot zero is reserved and searched as if taken
  assign act_eff = {active_q[gsa_pkg::SlotDepth-1:1], 1'b1};
  assign act_grp = act_eff;

  always_comb begin
    for (int g = 0; g < gsa_pkg::NumGroups; g++) begin
      grp_free[g] = ~&act_grp[g];
    end
  end

  assign grp_pick = first_set(grp_free);
  assign bit_pick = first_set(~act_grp[grp_q]);
  assign f_idx    = {grp_q, bit_pick[gsa_pkg::BitIdxW-1:0]};
  assign f_grant  = grp_found_q && bit_pick[gsa_pkg::BitIdxW] && (f_idx <= TopIdx);

  assign start      = (state_q == S_IDLE) && item_valid_i && (!rsp_valid_q || pop);
  assign item_pop_o = start;
  assign rd_addr    = (state_q == S_FIND) ? f_idx : item_i.req.handle_index;

  assign live = cur_q.handle_ok
             && ({1'b0, cur_q.req.handle_index} < hw_q)
             && active_q[cur_q.req.handle_index]
             && (rd_q.gen == cur_q.req.handle_generation);

  assign gen_old = ({1'b0, f_q} < hw_q) ? rd_q.gen : '0;
  assign gen_inc = gen_old + gsa_pkg::GenW'(1);
  assign gen_new = (gen_inc == '0) ? gsa_pkg::GenW'(1) : gen_inc;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_q.req.handle_index;
    mem_wdata = '{gen: rd_q.gen, shape: rd_q.shape, layer: cur_q.req.layer_bits};
    if (state_q == S_ACQ && grant_q) begin
      mem_we    = 1'b1;
      mem_waddr = f_q;
      mem_wdata = '{gen: gen_new, shape: cur_q.req.shape_kind,
                    layer: cur_q.req.layer_bits};
    end else if (state_q == S_EXEC && cur_q.op == gsa_pkg::OP_SET_LAYER && live) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    state_d  = state_q;
    active_d = active_q;
    hw_d     = hw_q;
    cnt_d    = cnt_q;
    done     = 1'b0;
    rsp_d    = rsp_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          rsp_d            = '0;
          rsp_d.slot_index = item_i.req.handle_index;
          rsp_d.live_count = cnt_q;
          unique case (item_i.op)
            gsa_pkg::OP_CLEAR: begin
              done             = 1'b1;
              active_d         = '0;
              cnt_d            = '0;
              rsp_d.ok         = 1'b1;
              rsp_d.live_count = '0;
            end
            gsa_pkg::OP_REJECT: begin
              done             = 1'b1;
              rsp_d.slot_index = '0;
            end
            gsa_pkg::OP_NOP:     done    = 1'b1;
            gsa_pkg::OP_ACQUIRE: state_d = S_FIND;
            default:             state_d = S_EXEC;
          endcase
        end
      end
      S_EXEC: begin
        done             = 1'b1;
        state_d          = S_IDLE;
        rsp_d            = '0;
        rsp_d.slot_index = cur_q.req.handle_index;
        if (live) begin
          rsp_d.ok              = 1'b1;
          rsp_d.slot_generation = rd_q.gen;
          rsp_d.slot_layer      = rd_q.layer;
          rsp_d.slot_shape      = rd_q.shape;
          if (cur_q.op == gsa_pkg::OP_SET_LAYER) begin
            rsp_d.slot_layer = cur_q.req.layer_bits;
          end
          if (cur_q.op == gsa_pkg::OP_RELEASE) begin
            rsp_d.slot_shape                  = gsa_pkg::SHAPE_NONE;
            active_d[cur_q.req.handle_index] = 1'b0;
            if (cnt_q != '0) begin
              cnt_d = cnt_q - gsa_pkg::CntW'(1);
            end
          end
        end
        rsp_d.live_count = cnt_d;
      end
      S_FIND: state_d = S_ACQ;
      S_ACQ: begin
        done    = 1'b1;
        state_d = S_IDLE;
        rsp_d   = '0;
        if (grant_q) begin
          active_d[f_q]         = 1'b1;
          cnt_d                 = cnt_q + gsa_pkg::CntW'(1);
          rsp_d.ok              = 1'b1;
          rsp_d.slot_index      = f_q;
          rsp_d.slot_generation = gen_new;
          rsp_d.slot_layer      = cur_q.req.layer_bits;
          rsp_d.slot_shape      = cur_q.req.shape_kind;
          if ({1'b0, f_q} >= hw_q) begin
            hw_d = {1'b0, f_q} + gsa_pkg::HwW'(1);
          end
        end
        rsp_d.live_count = cnt_d;
      end
      default: state_d = S_IDLE;
    endcase
    rsp_valid_d = (rsp_valid_q && !pop) || done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= '0;
      hw_q        <= gsa_pkg::HwW'(1);
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      hw_q        <= hw_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
      rsp_q       <= rsp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      cur_q       <= item_i;
      grp_q       <= grp_pick[gsa_pkg::GrpIdxW-1:0];
      grp_found_q <= grp_pick[gsa_pkg::GrpIdxW];
    end
    if (state_q == S_FIND) begin
      f_q     <= f_idx;
      grant_q <= f_grant;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  assign empty = !rsp_valid_q;
  assign rsp_o = rsp_q;

endmodule

// File: src/generational_slot_allocator.sv
// generational slot allocator: hands out and validates index/generation handles
// channels: request queue (push/full/req_i) and result queue (empty/pop/rsp_o)
// timing: a transaction is accepted when push is high and full is low. every
// request gives exactly one result, in order. clear-all, rejected and unknown
// requests finish in the back end's idle state; release/check/set-layer take a
// slot read then an update, acquire a group search, a bit search with slot
// read, and an update. the slot memory port and the two-level free search set
// these steps.
// a two-entry request queue keeps taking requests while the back end works or
// while a result waits; when the receiver does not pop, the result register
// holds and the back end waits before starting the next request, so full rises
// once two requests are queued.
// reset: all slots inactive, generations read as zero, high-water mark at one,
// live count zero; both queues empty. no clearing pass is needed.
// depends on gsa_pkg, gsa_front and gsa_back
module generational_slot_allocator #(
  parameter int MaxSlotIndex = gsa_pkg::DefMaxSlotIndex
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  gsa_pkg::req_t req_i,
  output logic          empty,
  input  logic          pop,
  output gsa_pkg::rsp_t rsp_o
);

  logic           item_valid;
  logic           item_pop;
  gsa_pkg::item_t item;

  gsa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .req_i        (req_i),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop),
    .item_o       (item)
  );

  gsa_back #(
    .MaxSlotIndex (MaxSlotIndex)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .item_i       (item),
    .empty        (empty),
    .pop          (pop),
    .rsp_o        (rsp_o)
  );

endmodule

// File: src/gsa_checker.sv
// port-level checker for the generational slot allocator, bound to the top level
// depends on gsa_pkg and assert_macros.svh
`include "assert_macros.svh"

module gsa_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          full,
  input logic          empty,
  input logic          pop,
  input gsa_pkg::rsp_t rsp_o
);

  `GSA_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(rsp_o))
  `GSA_ASSERT_IMP(a_fail_clean, clk_i, rst_ni, !empty && !rsp_o.ok,
                  rsp_o.slot_shape == gsa_pkg::SHAPE_NONE && rsp_o.slot_generation == '0)
  `GSA_ASSERT_IMP(a_gen_has_slot, clk_i, rst_ni, !empty && rsp_o.slot_generation != '0,
                  rsp_o.ok && rsp_o.slot_index != '0)
  `GSA_ASSERT_IMP(a_reset_idle, clk_i, rst_ni, $rose(rst_ni), empty && !full)

endmodule

bind generational_slot_allocator gsa_checker u_gsa_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .rsp_o  (rsp_o)
);

// File: bench/generational_slot_allocator_test.sv
// self-checking bench for the generational slot allocator: drives random and directed
// requests through the push/full side, pops results with random stalls and checks them
// against a slot table kept in the bench; depends on gsa_pkg and the allocator rtl
module generational_slot_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TopIndex   = (gsa_pkg::DefMaxSlotIndex > gsa_pkg::SlotDepth - 1) ?
                              gsa_pkg::SlotDepth - 1 : gsa_pkg::DefMaxSlotIndex;
  localparam int QuietLimit = 2000;
  localparam int HoldOff    = 80;
  localparam int DrainWait  = 20;
  localparam int MixedItems = 250;

  localparam logic [gsa_pkg::KindW-1:0]  KIND_SPARE_FIRST = 3'd5;
  localparam logic [gsa_pkg::ShapeW-1:0] SHAPE_BAD        = 2'd3;

  class slot_table_tracker;
    bit                         active    [gsa_pkg::SlotDepth];
    logic [gsa_pkg::GenW-1:0]   gen_tab   [gsa_pkg::SlotDepth];
    logic [gsa_pkg::ShapeW-1:0] shape_tab [gsa_pkg::SlotDepth];
    logic [gsa_pkg::LayerW-1:0] layer_tab [gsa_pkg::SlotDepth];
    int unsigned                high_mark;
    logic [gsa_pkg::CntW-1:0]   live;
    gsa_pkg::rsp_t              results_due [$];
    int unsigned                bad_results;
    int unsigned                checked;

    function new();
      foreach (active[i]) begin
        active[i]    = 1'b0;
        gen_tab[i]   = '0;
        shape_tab[i] = gsa_pkg::SHAPE_NONE;
        layer_tab[i] = '0;
      end
      high_mark   = 1;
      live        = '0;
      bad_results = 0;
      checked     = 0;
    endfunction

    function bit handle_live(gsa_pkg::req_t r);
      return r.handle_index != '0 && r.handle_generation != '0
        && 32'(r.handle_index) < high_mark
        && active[r.handle_index] && gen_tab[r.handle_index] == r.handle_generation;
    endfunction

    function void note_request(gsa_pkg::req_t r);
      gsa_pkg::rsp_t            want;
      int unsigned              s;
      logic [gsa_pkg::GenW-1:0] g;
      bit                       found;
      want = '0;
      want.slot_index = r.handle_index;
      found = 1'b0;
      s = 0;
      case (r.kind)
        gsa_pkg::KIND_ACQUIRE: begin
          want.slot_index = '0;
          if (r.shape_kind == gsa_pkg::SHAPE_BOX
              || r.shape_kind == gsa_pkg::SHAPE_SPHERE) begin
            for (int i = 1; i < high_mark && i < gsa_pkg::SlotDepth && !found; i++) begin
              if (!active[i]) begin
                s = i;
                found = 1'b1;
              end
            end
            if (!found && high_mark <= TopIndex) begin
              s = high_mark;
              high_mark++;
              found = 1'b1;
            end
          end
          if (found) begin
            g = gen_tab[s] + gsa_pkg::GenW'(1);
            if (g == '0) g = gsa_pkg::GenW'(1);
            gen_tab[s]   = g;
            shape_tab[s] = r.shape_kind;
            active[s]    = 1'b1;
            layer_tab[s] = r.layer_bits;
            live++;
            want.ok              = 1'b1;
            want.slot_index      = s[gsa_pkg::IdxW-1:0];
            want.slot_generation = g;
            want.slot_layer      = r.layer_bits;
            want.slot_shape      = r.shape_kind;
          end
        end
        gsa_pkg::KIND_RELEASE: begin
          if (handle_live(r)) begin
            s = 32'(r.handle_index);
            active[s]    = 1'b0;
            shape_tab[s] = gsa_pkg::SHAPE_NONE;
            if (live != '0) live--;
            want.ok              = 1'b1;
            want.slot_generation = gen_tab[s];
            want.slot_layer      = layer_tab[s];
          end
        end
        gsa_pkg::KIND_CHECK, gsa_pkg::KIND_SET_LAYER: begin
          if (handle_live(r)) begin
            s = 32'(r.handle_index);
            if (r.kind == gsa_pkg::KIND_SET_LAYER) layer_tab[s] = r.layer_bits;
            want.ok              = 1'b1;
            want.slot_generation = gen_tab[s];
            want.slot_layer      = layer_tab[s];
            want.slot_shape      = shape_tab[s];
          end
        end
        gsa_pkg::KIND_CLEAR: begin
          for (int i = 1; i < high_mark && i < gsa_pkg::SlotDepth; i++) begin
            active[i]    = 1'b0;
            shape_tab[i] = gsa_pkg::SHAPE_NONE;
          end
          live = '0;
          want.ok = 1'b1;
        end
        default: ;
      endcase
      want.live_count = live;
      results_due.push_back(want);
    endfunction

    function void check_result(gsa_pkg::rsp_t got);
      gsa_pkg::rsp_t want;
      checked++;
      if (results_due.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("result %0d arrived with nothing outstanding: %h", checked, got);
        return;
      end
      want = results_due.pop_front();
      if (got.ok !== want.ok || got.slot_index !== want.slot_index
          || got.slot_generation !== want.slot_generation
          || got.slot_layer !== want.slot_layer || got.slot_shape !== want.slot_shape
          || got.live_count !== want.live_count) begin
        bad_results++;
        if (bad_results <= 10) begin
          $display("result %0d wrong: want ok=%b idx=%0d gen=%0d layer=%h shape=%0d live=%0d",
                   checked, want.ok, want.slot_index, want.slot_generation, want.slot_layer,
                   want.slot_shape, want.live_count);
          $display("  got ok=%b idx=%0d gen=%0d layer=%h shape=%0d live=%0d",
                   got.ok, got.slot_index, got.slot_generation, got.slot_layer,
                   got.slot_shape, got.live_count);
        end
      end
    endfunction
  endclass

  logic          clk_i;
  logic          rst_ni  = 1'b0;
  logic          push    = 1'b0;
  logic          pop     = 1'b0;
  gsa_pkg::req_t request = '0;
  logic          full;
  logic          empty;
  gsa_pkg::rsp_t result;

  slot_table_tracker slots = new();
  int unsigned sent_count = 0;
  int unsigned got_count  = 0;
  bit          hold_request = 1'b0;

  generational_slot_allocator u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .req_i  (request),
    .empty  (empty),
    .pop    (pop),
    .rsp_o  (result)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic gsa_pkg::req_t make_req(input logic [gsa_pkg::KindW-1:0] kind,
                                             input logic [gsa_pkg::IdxW-1:0] idx,
                                             input logic [gsa_pkg::GenW-1:0] gen,
                                             input logic [gsa_pkg::ShapeW-1:0] shape,
                                             input logic [gsa_pkg::LayerW-1:0] layer);
    gsa_pkg::req_t r;
    r.kind              = kind;
    r.handle_index      = idx;
    r.handle_generation = gen;
    r.shape_kind        = shape;
    r.layer_bits        = layer;
    return r;
  endfunction

  function automatic int any_live();
    int idx_list [$];
    for (int i = 1; i < gsa_pkg::SlotDepth; i++) begin
      if (slots.active[i]) idx_list.push_back(i);
    end
    if (idx_list.size() == 0) return 0;
    return idx_list[$urandom_range(0, idx_list.size() - 1)];
  endfunction

  function automatic logic [gsa_pkg::ShapeW-1:0] good_shape();
    return $urandom_range(0, 1) ? gsa_pkg::SHAPE_SPHERE : gsa_pkg::SHAPE_BOX;
  endfunction

  function automatic gsa_pkg::req_t random_request();
    gsa_pkg::req_t r;
    int unsigned   roll;
    int            pick;
    int unsigned   idx_top;
    pick = any_live();
    r = make_req(gsa_pkg::KIND_ACQUIRE, gsa_pkg::IdxW'($urandom), gsa_pkg::GenW'($urandom),
                 gsa_pkg::ShapeW'($urandom), $urandom);
    roll = $urandom_range(0, 99);
    if (roll < 35 || (roll < 82 && pick == 0)) begin
      r.kind = gsa_pkg::KIND_ACQUIRE;
      if ($urandom_range(0, 19) == 0)
        r.shape_kind = $urandom_range(0, 1) ? SHAPE_BAD : gsa_pkg::SHAPE_NONE;
      else
        r.shape_kind = good_shape();
    end else if (roll < 82) begin
      r.kind = (roll < 55) ? gsa_pkg::KIND_RELEASE :
               (roll < 70) ? gsa_pkg::KIND_CHECK : gsa_pkg::KIND_SET_LAYER;
      r.handle_index      = gsa_pkg::IdxW'(pick);
      r.handle_generation = slots.gen_tab[pick];
    end else if (roll < 90) begin
      // handles that must be rejected
      r.kind = gsa_pkg::KindW'(gsa_pkg::KIND_RELEASE + $urandom_range(0, 2));
      case ($urandom_range(0, 2))
        0: begin
          idx_top = (slots.high_mark > 1) ? slots.high_mark - 1 : 1;
          r.handle_index = gsa_pkg::IdxW'($urandom_range(1, idx_top));
          r.handle_generation =
            gsa_pkg::GenW'(slots.gen_tab[r.handle_index] + $urandom_range(1, 255));
        end
        1: begin
          if (pick != 0) r.handle_index = gsa_pkg::IdxW'(pick);
          r.handle_generation = '0;
        end
        default: r.handle_index = '0;
      endcase
    end else if (roll < 93) begin
      r.kind = gsa_pkg::KIND_CLEAR;
    end else if (roll < 97) begin
      r.kind = gsa_pkg::KindW'(KIND_SPARE_FIRST + $urandom_range(0, 2));
    end else begin
      r.kind = gsa_pkg::KindW'($urandom_range(0, 7));
    end
    return r;
  endfunction

  task automatic offer_request(input gsa_pkg::req_t r);
    int unsigned gap;
    gap = (sent_count % 90 < 25) ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    request <= r;
    do @(posedge clk_i); while (full);
    slots.note_request(r);
    sent_count++;
  endtask

  task automatic settle_results();
    push <= 1'b0;
    do @(posedge clk_i); while (slots.results_due.size() != 0);
  endtask

  task automatic offer_acquire();
    offer_request(make_req(gsa_pkg::KIND_ACQUIRE, gsa_pkg::IdxW'($urandom),
                           gsa_pkg::GenW'($urandom), good_shape(), $urandom));
  endtask

  // sender
  initial begin
    int fill_count;
    int pick;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    offer_request(make_req(gsa_pkg::KIND_CHECK, 8'd0, 8'd0, gsa_pkg::SHAPE_NONE, 32'h0));
    offer_request(make_req(gsa_pkg::KIND_RELEASE, 8'hff, 8'hff, SHAPE_BAD, 32'hffff_ffff));
    offer_request(make_req(gsa_pkg::KIND_SET_LAYER, 8'd1, 8'd1, gsa_pkg::SHAPE_BOX,
                           32'hffff_ffff));
    offer_request(make_req(gsa_pkg::KIND_ACQUIRE, 8'd0, 8'd0, gsa_pkg::SHAPE_NONE,
                           32'h1234_5678));
    offer_request(make_req(gsa_pkg::KIND_ACQUIRE, 8'hff, 8'hff, SHAPE_BAD, 32'h1234_5678));
    offer_request(make_req(gsa_pkg::KIND_ACQUIRE, 8'd0, 8'd0, gsa_pkg::SHAPE_BOX, 32'h0));
    offer_request(make_req(gsa_pkg::KIND_ACQUIRE, 8'hff, 8'hff, gsa_pkg::SHAPE_SPHERE,
                           32'hffff_ffff));
    offer_request(make_req(gsa_pkg::KIND_CHECK, 8'd1, 8'd1, gsa_pkg::SHAPE_NONE, 32'h0));
    offer_request(make_req(gsa_pkg::KIND_SET_LAYER, 8'd2, 8'd1, gsa_pkg::SHAPE_NONE,
                           32'ha5a5_a5a5));
    offer_request(make_req(gsa_pkg::KIND_CHECK, 8'd2, 8'd1, gsa_pkg::SHAPE_NONE, 32'h0));
    offer_request(make_req(gsa_pkg::KIND_CHECK, 8'd2, 8'd2, gsa_pkg::SHAPE_NONE, 32'h0));
    offer_request(make_req(gsa_pkg::KIND_CHECK, 8'd1, 8'd0, gsa_pkg::SHAPE_NONE, 32'h0));
    offer_request(make_req(gsa_pkg::KIND_CHECK, 8'd3, 8'd1, gsa_pkg::SHAPE_NONE, 32'h0));
    offer_request(make_req(gsa_pkg::KIND_RELEASE, 8'd1, 8'd1, gsa_pkg::SHAPE_NONE, 32'h0));
    offer_request(make_req(gsa_pkg::KIND_RELEASE, 8'd1, 8'd1, gsa_pkg::SHAPE_NONE, 32'h0));
    offer_request(make_req(gsa_pkg::KIND_ACQUIRE, 8'd0, 8'd0, gsa_pkg::SHAPE_BOX,
                           32'h5a5a_5a5a));
    for (int k = 0; k < 3; k++)
      offer_request(make_req(gsa_pkg::KindW'(KIND_SPARE_FIRST + k), 8'hff, 8'hff, SHAPE_BAD,
                             32'hffff_ffff));
    offer_request(make_req(gsa_pkg::KIND_CLEAR, 8'hff, 8'hff, SHAPE_BAD, 32'hffff_ffff));
    offer_request(make_req(gsa_pkg::KIND_CHECK, 8'd1, 8'd2, gsa_pkg::SHAPE_NONE, 32'h0));
    offer_request(make_req(gsa_pkg::KIND_ACQUIRE, 8'd0, 8'd0, gsa_pkg::SHAPE_SPHERE,
                           32'h8000_0001));
    offer_request(make_req(gsa_pkg::KIND_CLEAR, 8'd0, 8'd0, gsa_pkg::SHAPE_NONE, 32'h0));
    settle_results();

    // fill the whole table while the result side stalls for a while
    fill_count = 0;
    while (int'(slots.live) != TopIndex) begin
      if (fill_count == 20) hold_request = 1'b1;
      pick = any_live();
      if (fill_count % 10 == 7 && pick != 0)
        offer_request(make_req(gsa_pkg::KIND_CHECK, gsa_pkg::IdxW'(pick), slots.gen_tab[pick],
                               gsa_pkg::SHAPE_NONE, $urandom));
      else
        offer_acquire();
      fill_count++;
    end
    offer_acquire();
    settle_results();

    offer_request(make_req(gsa_pkg::KIND_CLEAR, gsa_pkg::IdxW'($urandom),
                           gsa_pkg::GenW'($urandom), gsa_pkg::ShapeW'($urandom), $urandom));
    repeat (MixedItems) offer_request(random_request());

    settle_results();
    repeat (DrainWait) @(posedge clk_i);
    if (slots.bad_results == 0 && slots.results_due.size() == 0) begin
      $display("generational_slot_allocator: match");
    end else begin
      $display("generational_slot_allocator: mismatch");
    end
    $finish;
  end

  // receiver
  initial begin
    int unsigned pause;
    @(posedge rst_ni);
    forever begin
      pause = (got_count % 70 < 20) ? 0 : $urandom_range(0, 11);
      if (hold_request) begin
        hold_request = 1'b0;
        pause = HoldOff;
      end
      if (pause != 0) begin
        pop <= 1'b0;
        repeat (pause) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      slots.check_result(result);
      got_count++;
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("generational_slot_allocator: mismatch");
    $finish;
  end

endmodule
